// File: rtl/ray_cube_intersection_defines.svh
// Assertion macros used by the ray cube intersection top level.
`ifndef RAY_CUBE_INTERSECTION_DEFINES_SVH
`define RAY_CUBE_INTERSECTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ray cube intersection: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ray cube intersection: next-cycle check failed");

`endif

// File: rtl/rci_pkg.sv
// Types and constants for the ray cube intersection block.
`timescale 1ns / 1ps
package rci_pkg;

    localparam int          QW         = 31;
    localparam int          DIV_STEPS  = 4;
    localparam int          DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int          BND_W      = 35;
    localparam int          NFACE      = 6;
    localparam logic [30:0] EPS        = 31'd7;
    localparam logic [30:0] T_MAX      = 31'h7FFF_FFFF;

    localparam logic [2:0] FACE_NZ = 3'd0;
    localparam logic [2:0] FACE_PZ = 3'd1;
    localparam logic [2:0] FACE_NX = 3'd2;
    localparam logic [2:0] FACE_PX = 3'd3;
    localparam logic [2:0] FACE_NY = 3'd4;
    localparam logic [2:0] FACE_PY = 3'd5;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] REG_CX   = 2'd0;
    localparam logic [1:0] REG_CY   = 2'd1;
    localparam logic [1:0] REG_CZ   = 2'd2;
    localparam logic [1:0] REG_EDGE = 2'd3;

    typedef logic signed [BND_W-1:0] t_bnd;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic               hit;
        logic [30:0]        hit_distance;
        logic [2:0]         face_code;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_res;

    // Divider working set: partial remainder, remaining numerator bits, divisor and skip flag.
    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] nlow;
        logic [31:0] den;
        logic        skip;
    } t_div;

    typedef struct packed {
        logic [30:0] q;
        logic        skip;
    } t_quo;

    typedef struct packed {
        logic               ok;
        logic [30:0]        t;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_face;

    function automatic logic [1:0] face_axis(input int f);
        logic [1:0] ax;
        if (f < 2) begin
            ax = AX_Z;
        end else if (f < 4) begin
            ax = AX_X;
        end else begin
            ax = AX_Y;
        end
        return ax;
    endfunction

endpackage

// File: rtl/rci_div.sv
// Pipelined restoring divider producing a 31-bit quotient four bits per stage (three in the last).
`timescale 1ns / 1ps
module rci_div
    import rci_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_in,
    output t_quo o_out
);

    t_div        r_st [DIV_STAGES];
    logic [30:0] r_q  [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int CNT = (s == DIV_STAGES - 1) ? (QW - s * DIV_STEPS) : DIV_STEPS;
        t_div        w_st;
        logic [30:0] w_q;
        t_div        n_st;
        logic [30:0] n_q;

        // The first stage takes the set-up word; later stages take their predecessor.
        if (s == 0) begin : g_src
            assign w_st = i_in;
            assign w_q  = '0;
        end else begin : g_src
            assign w_st = r_st[s-1];
            assign w_q  = r_q[s-1];
        end

        always_comb begin
            logic [32:0] sh;
            n_st = w_st;
            n_q  = w_q;
            for (int k = 0; k < CNT; k++) begin
                sh = {n_st.rem, n_st.nlow[30]};
                if (sh >= {1'b0, n_st.den}) begin
                    sh  = sh - {1'b0, n_st.den};
                    n_q = {n_q[29:0], 1'b1};
                end else begin
                    n_q = {n_q[29:0], 1'b0};
                end
                n_st.rem  = sh[31:0];
                n_st.nlow = {n_st.nlow[29:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st;
                r_q[s]  <= n_q;
            end
        end
    end

    assign o_out.q    = r_q[DIV_STAGES-1];
    assign o_out.skip = r_st[DIV_STAGES-1].skip;

endmodule

// File: rtl/rci_point.sv
// Hit point and bounds test for one face: multiply stage, then add and compare.
`timescale 1ns / 1ps
module rci_point
    import rci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_quo        i_quo,
    input  t_ray        i_ray,
    input  t_bnd        i_lo [3],
    input  t_bnd        i_hi [3],
    output t_face       o_face
);

    logic signed [63:0] r_prod [3];
    logic signed [31:0] r_org  [3];
    logic [30:0]        r_t;
    logic               r_pre_ok;
    t_face              r_face;
    t_face              n_face;

    logic signed [31:0] qs;
    logic signed [31:0] dirv [3];
    logic signed [31:0] orgv [3];

    assign qs      = $signed({1'b0, i_quo.q});
    assign dirv[0] = i_ray.dir_x;
    assign dirv[1] = i_ray.dir_y;
    assign dirv[2] = i_ray.dir_z;
    assign orgv[0] = i_ray.origin_x;
    assign orgv[1] = i_ray.origin_y;
    assign orgv[2] = i_ray.origin_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= qs * dirv[a];
                r_org[a]  <= orgv[a];
            end
            r_t      <= i_quo.q;
            r_pre_ok <= !i_quo.skip && (i_quo.q > EPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_face <= n_face;
        end
    end

    always_comb begin
        logic signed [48:0] p [3];
        logic signed [48:0] lo_e;
        logic signed [48:0] hi_e;
        logic               in_box;
        logic signed [31:0] ps [3];
        in_box = 1'b1;
        for (int a = 0; a < 3; a++) begin
            p[a] = 49'(r_org[a]) + 49'($signed(r_prod[a][63:16]));
            lo_e = 49'(i_lo[a]) - 49'(EPS);
            hi_e = 49'(i_hi[a]) + 49'(EPS);
            if (p[a] < lo_e || p[a] > hi_e) begin
                in_box = 1'b0;
            end
            if (p[a] > 49'sd2147483647) begin
                ps[a] = 32'sh7FFF_FFFF;
            end else if (p[a] < -49'sd2147483648) begin
                ps[a] = 32'sh8000_0000;
            end else begin
                ps[a] = p[a][31:0];
            end
        end
        n_face.ok = r_pre_ok && in_box;
        n_face.t  = r_t;
        n_face.px = ps[0];
        n_face.py = ps[1];
        n_face.pz = ps[2];
    end

    assign o_face = r_face;

endmodule

// File: rtl/ray_cube_intersection.sv
// Top level of the pipelined ray versus axis-aligned cube intersector.
// The block takes one ray beat per cycle while o_stall is low and returns one
// result beat per ray, in order. Each of the six face planes has its own
// pipelined divider (four quotient bits per stage, eight stages), which sets
// the depth; two more stages form the hit points and test them against the
// cube, and two stages pick the nearest face in the order -z, +z, -x, +x, -y,
// +y. The whole pipeline advances together, so o_stall rises only while a
// finished result sits unclaimed in the output register and i_stall is high.
// Cube registers are written through the plain write port and must only change
// while no ray is in flight.
`timescale 1ns / 1ps
`include "ray_cube_intersection_defines.svh"
module ray_cube_intersection
    import rci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_ray        i_ray,
    output logic        o_valid,
    input  logic        i_stall,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int NV = DIV_STAGES + 6;

    // Configuration registers.
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_edge <= 31'h0001_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CX:   r_cx   <= i_cfg_data;
                REG_CY:   r_cy   <= i_cfg_data;
                REG_CZ:   r_cz   <= i_cfg_data;
                REG_EDGE: r_edge <= i_cfg_data[30:0];
                default:  ;
            endcase
        end
    end

    // Cube bounds, computed wide so that nothing wraps.
    t_bnd lo [3];
    t_bnd hi [3];
    t_bnd half;

    assign half  = BND_W'({1'b0, r_edge[30:1]});
    assign lo[0] = BND_W'(r_cx) - half;
    assign hi[0] = BND_W'(r_cx) + half;
    assign lo[1] = BND_W'(r_cy);
    assign hi[1] = BND_W'(r_cy) + BND_W'({1'b0, r_edge});
    assign lo[2] = BND_W'(r_cz) - half;
    assign hi[2] = BND_W'(r_cz) + half;

    // The pipeline moves as one; valid bits ride alongside the data.
    logic          en;
    logic [NV-1:0] r_vld;

    assign en      = !r_vld[NV-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // Stage 0: input register.
    t_ray r_s0_ray;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_ray <= i_ray;
        end
    end

    // Stage 1: per face, plane distance and divider set-up. The quotient is
    // taken on magnitudes; a negative quotient can never pass the epsilon test,
    // so only its sign is kept, folded into the skip flag together with a zero
    // direction and a quotient that would saturate.
    t_ray r_s1_ray;
    t_div r_s1_div [NFACE];
    t_div n_s1_div [NFACE];

    always_comb begin
        logic signed [31:0] ov [3];
        logic signed [31:0] dv [3];
        logic [1:0]         ax;
        t_bnd               plane;
        t_bnd               diff;
        logic [33:0]        diff_abs;
        logic [31:0]        d_abs;
        logic [31:0]        hi19;
        logic               sat;
        ov[0] = r_s0_ray.origin_x;
        ov[1] = r_s0_ray.origin_y;
        ov[2] = r_s0_ray.origin_z;
        dv[0] = r_s0_ray.dir_x;
        dv[1] = r_s0_ray.dir_y;
        dv[2] = r_s0_ray.dir_z;
        for (int f = 0; f < NFACE; f++) begin
            ax       = face_axis(f);
            plane    = (f % 2 == 1) ? hi[ax] : lo[ax];
            diff     = plane - BND_W'(ov[ax]);
            diff_abs = diff[BND_W-1] ? 34'(-diff) : diff[33:0];
            d_abs    = dv[ax][31] ? (~dv[ax] + 32'd1) : dv[ax];
            hi19     = {13'd0, diff_abs[33:15]};
            sat      = hi19 >= d_abs;
            n_s1_div[f].rem  = sat ? 32'd0 : hi19;
            n_s1_div[f].nlow = {diff_abs[14:0], 16'd0};
            n_s1_div[f].den  = d_abs;
            n_s1_div[f].skip = (dv[ax] == '0) || (diff[BND_W-1] != dv[ax][31]) || sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ray <= r_s0_ray;
            r_s1_div <= n_s1_div;
        end
    end

    // Divider stages, with the ray carried along in a delay line.
    t_quo quo [NFACE];
    t_ray r_dray [DIV_STAGES];

    for (genvar f = 0; f < NFACE; f++) begin : g_div
        rci_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_in  (r_s1_div[f]),
            .o_out (quo[f])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dray[0] <= r_s1_ray;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dray[s] <= r_dray[s-1];
            end
        end
    end

    // Hit points and bounds tests, two stages.
    t_face face [NFACE];

    for (genvar f = 0; f < NFACE; f++) begin : g_pt
        rci_point u_point (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_quo  (quo[f]),
            .i_ray  (r_dray[DIV_STAGES-1]),
            .i_lo   (lo),
            .i_hi   (hi),
            .o_face (face[f])
        );
    end

    // Nearest face selection: first half of the faces, then the second half.
    // A strict compare keeps the earlier face on a tie.
    t_res  r_sa;
    t_face r_sa_rest [3];
    t_res  n_sa;
    t_res  n_out;
    t_res  r_out;

    always_comb begin
        n_sa.hit          = 1'b0;
        n_sa.hit_distance = T_MAX;
        n_sa.face_code    = FACE_NZ;
        n_sa.point_x      = '0;
        n_sa.point_y      = '0;
        n_sa.point_z      = '0;
        for (int f = 0; f < 3; f++) begin
            if (face[f].ok && face[f].t < n_sa.hit_distance) begin
                n_sa.hit          = 1'b1;
                n_sa.hit_distance = face[f].t;
                n_sa.face_code    = 3'(f);
                n_sa.point_x      = face[f].px;
                n_sa.point_y      = face[f].py;
                n_sa.point_z      = face[f].pz;
            end
        end
    end

    always_comb begin
        n_out = r_sa;
        for (int f = 0; f < 3; f++) begin
            if (r_sa_rest[f].ok && r_sa_rest[f].t < n_out.hit_distance) begin
                n_out.hit          = 1'b1;
                n_out.hit_distance = r_sa_rest[f].t;
                n_out.face_code    = 3'(f + 3);
                n_out.point_x      = r_sa_rest[f].px;
                n_out.point_y      = r_sa_rest[f].py;
                n_out.point_z      = r_sa_rest[f].pz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa  <= n_sa;
            r_out <= n_out;
            for (int f = 0; f < 3; f++) begin
                r_sa_rest[f] <= face[f + 3];
            end
        end
    end

    assign o_res = r_out;

    // A hit always lies beyond epsilon on a real face.
    `RCI_ASSERT_IMPL(a_hit_sane, o_valid && o_res.hit, (o_res.hit_distance > EPS) && (o_res.face_code <= FACE_PY))
    // A miss reports the saturated distance, face zero and a zero point.
    `RCI_ASSERT_IMPL(a_miss_clean, o_valid && !o_res.hit, (o_res.hit_distance == T_MAX) && (o_res.face_code == FACE_NZ) && (o_res.point_x == 0) && (o_res.point_y == 0) && (o_res.point_z == 0))
    // An accepted beat always enters the first stage.
    `RCI_ASSERT_NEXT(a_enter, i_valid && !o_stall, r_vld[0])

endmodule

// File: test/tb_ray_cube_intersection.sv
// Self-checking testbench for the ray cube intersection block.
`timescale 1ns / 1ps
module tb_ray_cube_intersection;
    import rci_pkg::*;

    localparam longint ONE       = 65536;
    localparam int     WDOG_MAX  = 5000;
    localparam int     PHASE_LEN = 210;
    localparam int     DRAIN     = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_ray        i_ray;
    logic        o_valid;
    logic        i_stall;
    t_res        o_res;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    ray_cube_intersection u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ray      (i_ray),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the cube registers, updated once all four writes of a cube are made.
    longint cube_ctr [3];
    longint cube_edge;

    // Results still owed by the block, oldest first.
    t_res   owed_hits[$];
    int     n_err;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;

    typedef struct {
        t_ray ray;
        bit   typed;
        t_res res;
    } t_row;

    t_row directed[$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Nearest accepted face plane, worked out with exact 64-bit arithmetic.
    // Axis index 0 is x, 1 is y and 2 is z.
    function automatic t_res nearest_face(input t_ray r);
        longint org [3];
        longint dir [3];
        longint lo  [3];
        longint hi  [3];
        longint p   [3];
        longint pb  [3];
        longint half, best, plane, t, lim;
        logic   found, in_box;
        logic [2:0] fbest;
        int     ax;
        t_res   res;
        org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
        dir[0] = r.dir_x;    dir[1] = r.dir_y;    dir[2] = r.dir_z;
        half  = cube_edge >>> 1;
        lo[0] = cube_ctr[0] - half; hi[0] = cube_ctr[0] + half;
        lo[1] = cube_ctr[1];        hi[1] = cube_ctr[1] + cube_edge;
        lo[2] = cube_ctr[2] - half; hi[2] = cube_ctr[2] + half;
        best  = longint'(T_MAX);
        found = 1'b0;
        fbest = FACE_NZ;
        for (int a = 0; a < 3; a++) pb[a] = 0;
        for (int f = 0; f < NFACE; f++) begin
            ax    = (f < 2) ? 2 : (f < 4) ? 0 : 1;
            plane = f[0] ? hi[ax] : lo[ax];
            if (dir[ax] == 0) continue;
            // Integer division truncates toward zero, as the hardware does.
            t = ((plane - org[ax]) * ONE) / dir[ax];
            if (t > longint'(T_MAX)) t = longint'(T_MAX);
            if (t <= longint'(EPS) || t >= best) continue;
            in_box = 1'b1;
            for (int a = 0; a < 3; a++) begin
                // Arithmetic shift on a signed value rounds toward minus infinity.
                p[a] = org[a] + ((t * dir[a]) >>> 16);
                if (p[a] < lo[a] - longint'(EPS) || p[a] > hi[a] + longint'(EPS))
                    in_box = 1'b0;
            end
            if (in_box) begin
                found = 1'b1;
                best  = t;
                fbest = 3'(f);
                for (int a = 0; a < 3; a++) pb[a] = p[a];
            end
        end
        for (int a = 0; a < 3; a++) begin
            lim = pb[a];
            if (lim > 64'sd2147483647) lim = 64'sd2147483647;
            if (lim < -64'sd2147483648) lim = -64'sd2147483648;
            pb[a] = lim;
        end
        res.hit          = found;
        res.hit_distance = best[30:0];
        res.face_code    = fbest;
        res.point_x      = pb[0][31:0];
        res.point_y      = pb[1][31:0];
        res.point_z      = pb[2][31:0];
        return res;
    endfunction

    function automatic t_ray mk_ray(input longint ox, oy, oz, dx, dy, dz);
        t_ray r;
        r.origin_x = ox[31:0]; r.origin_y = oy[31:0]; r.origin_z = oz[31:0];
        r.dir_x    = dx[31:0]; r.dir_y    = dy[31:0]; r.dir_z    = dz[31:0];
        return r;
    endfunction

    function automatic t_res mk_res(input logic h, input longint t, input logic [2:0] f,
                                    input longint px, py, pz);
        t_res r;
        r.hit = h; r.hit_distance = t[30:0]; r.face_code = f;
        r.point_x = px[31:0]; r.point_y = py[31:0]; r.point_z = pz[31:0];
        return r;
    endfunction

    // Random signed offset whose magnitude spans many octaves.
    function automatic longint spread_offset();
        longint m;
        m = longint'($urandom) & ((64'sd1 <<< $urandom_range(4, 26)) - 1);
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    // A ray aimed at a point in or on the cube, so that most beats land a hit;
    // some components are zeroed and some targets sit exactly on a face plane.
    function automatic t_ray aimed_ray();
        longint lo [3];
        longint span [3];
        longint tgt [3];
        longint off [3];
        longint half;
        half    = cube_edge >>> 1;
        lo[0]   = cube_ctr[0] - half; lo[1] = cube_ctr[1]; lo[2] = cube_ctr[2] - half;
        span[0] = 2 * half; span[1] = cube_edge; span[2] = 2 * half;
        for (int a = 0; a < 3; a++) begin
            case ($urandom_range(0, 5))
                0: begin
                    tgt[a] = lo[a];
                end
                1: begin
                    tgt[a] = lo[a] + span[a];
                end
                default: begin
                    tgt[a] = lo[a] + ((longint'($urandom) * span[a]) >>> 32);
                end
            endcase
            off[a] = spread_offset();
            if ($urandom_range(0, 7) == 0) off[a] = 0;
        end
        return mk_ray(tgt[0] + off[0], tgt[1] + off[1], tgt[2] + off[2],
                      -off[0], -off[1], -off[2]);
    endfunction

    task automatic cube_write(input longint cx, cy, cz, input longint edge_len);
        logic [31:0] vals [4];
        vals[REG_CX] = cx[31:0]; vals[REG_CY] = cy[31:0];
        vals[REG_CZ] = cz[31:0]; vals[REG_EDGE] = {1'b0, edge_len[30:0]};
        // The enable stays high across the four writes, one register per edge.
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cube_ctr[0] = longint'(signed'(vals[REG_CX]));
        cube_ctr[1] = longint'(signed'(vals[REG_CY]));
        cube_ctr[2] = longint'(signed'(vals[REG_CZ]));
        cube_edge   = longint'(vals[REG_EDGE][30:0]);
    endtask

    // Offers one ray beat and holds it until the block takes it. The expected
    // result is queued at the edge of acceptance.
    task automatic send_ray(input t_ray r, input bit typed, input t_res known);
        if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ray   <= r;
        do @(posedge i_clk); while (o_stall);
        owed_hits.push_back(typed ? known : nearest_face(r));
    endtask

    // Lets the pipeline empty before the cube registers are touched.
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (owed_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Receiver side: random back-pressure at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= (recv_stall_pct > 0) && ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    // Result checker: every result beat is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_hits.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("Unexpected result beat: %p", o_res);
            end else begin
                want = owed_hits.pop_front();
                if (o_res.hit !== want.hit || o_res.hit_distance !== want.hit_distance ||
                    o_res.face_code !== want.face_code || o_res.point_x !== want.point_x ||
                    o_res.point_y !== want.point_y || o_res.point_z !== want.point_z) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("Mismatch: expected hit=%0b t=%h face=%0d p=(%h,%h,%h)",
                                 want.hit, want.hit_distance, want.face_code,
                                 want.point_x, want.point_y, want.point_z);
                        $display("          actual   hit=%0b t=%h face=%0d p=(%h,%h,%h)",
                                 o_res.hit, o_res.hit_distance, o_res.face_code,
                                 o_res.point_x, o_res.point_y, o_res.point_z);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_res  none;
        longint mx, mn;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ray          = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_CX;
        i_cfg_data     = '0;
        n_err          = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cube_ctr[0] = 0; cube_ctr[1] = 0; cube_ctr[2] = 0;
        cube_edge   = ONE;
        mx   = 64'sd2147483647;
        mn   = -64'sd2147483648;
        none = mk_res(1'b0, longint'(T_MAX), FACE_NZ, 0, 0, 0);

        // Directed rays against the reset cube: x and z in [-0.5, 0.5], y in [0, 1].
        // A straight shot along +z from z = -2 hits the -z face at t = 1.5.
        directed.push_back('{mk_ray(0, ONE/2, -2*ONE, 0, 0, ONE), 1'b1,
                             mk_res(1'b1, 3*ONE/2, FACE_NZ, 0, ONE/2, -ONE/2)});
        // A zero direction skips every face.
        directed.push_back('{mk_ray(0, ONE/2, -2*ONE, 0, 0, 0), 1'b1, none});
        // Pointing away gives negative t on both z faces.
        directed.push_back('{mk_ray(0, ONE/2, -2*ONE, 0, 0, -ONE), 1'b1, none});
        directed.push_back('{mk_ray(-2*ONE, ONE/2, 0, ONE, 0, 0), 1'b1,
                             mk_res(1'b1, 3*ONE/2, FACE_NX, -ONE/2, ONE/2, 0)});
        directed.push_back('{mk_ray(2*ONE, ONE/2, 0, -ONE, 0, 0), 1'b0, none});
        directed.push_back('{mk_ray(0, -2*ONE, 0, 0, ONE, 0), 1'b0, none});
        directed.push_back('{mk_ray(0, 3*ONE, 0, 0, -ONE, 0), 1'b0, none});
        directed.push_back('{mk_ray(0, ONE/2, 2*ONE, 0, 0, -ONE), 1'b0, none});
        // Origin on a face gives t of zero there, at or below epsilon.
        directed.push_back('{mk_ray(0, ONE/2, -ONE/2, 0, 0, ONE), 1'b0, none});
        // Through an edge, where two faces tie, and along a diagonal.
        directed.push_back('{mk_ray(-2*ONE, ONE/2, -2*ONE, ONE, 0, ONE), 1'b0, none});
        directed.push_back('{mk_ray(-2*ONE, -2*ONE, -2*ONE, ONE, ONE, ONE), 1'b0, none});
        // Just outside the widened bounds, and just inside them.
        directed.push_back('{mk_ray(ONE/2 + 8, ONE/2, -2*ONE, 0, 0, ONE), 1'b0, none});
        directed.push_back('{mk_ray(ONE/2 + 7, ONE/2, -2*ONE, 0, 0, ONE), 1'b0, none});
        // Tiny direction: t saturates, so the face never wins.
        directed.push_back('{mk_ray(0, ONE/2, -2*ONE, 0, 0, 1), 1'b0, none});
        // Field extremes.
        directed.push_back('{mk_ray(mn, mn, mn, mn, mn, mn), 1'b0, none});
        directed.push_back('{mk_ray(mx, mx, mx, mx, mx, mx), 1'b0, none});
        directed.push_back('{mk_ray(mn, mx, mn, mx, mn, mx), 1'b0, none});
        directed.push_back('{mk_ray(mx, mn, mx, mn, mx, mn), 1'b0, none});
        directed.push_back('{mk_ray(0, ONE/2, 0, mx, mn, mx), 1'b0, none});
        directed.push_back('{mk_ray(0, ONE/2, 0, 1, -1, 1), 1'b0, none});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_ray(directed[k].ray, directed[k].typed, directed[k].res);

        // Random phases, each with its own cube and one of four idling patterns. The first
        // keeps the reset cube; the extremes of every register come later.
        for (int ph = 0; ph < 6; ph++) begin
            drain_pipe();
            case (ph)
                1: cube_write(0, 0, 0, 2 * ONE);
                2: cube_write(mn, mn, mn, mx);
                3: cube_write(mx, mx, mx, 0);
                4: cube_write(mx, mn, mx, 1);
                5: cube_write(spread_offset(), spread_offset(), spread_offset(),
                              longint'($urandom_range(1, 1 << 22)));
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int k = 0; k < PHASE_LEN; k++) begin
                // Now and then a stretch runs with no idling at all.
                if (k == PHASE_LEN / 2 && ph % 4 != 0) begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                if ($urandom_range(1, 100) <= 80) begin
                    send_ray(aimed_ray(), 1'b0, none);
                end else begin
                    send_ray(mk_ray($urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom), 1'b0, none);
                end
            end
        end

        drain_pipe();
        if (n_err == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/rci_pkg.sv
rtl/rci_div.sv
rtl/rci_point.sv
rtl/ray_cube_intersection.sv
test/tb_ray_cube_intersection.sv
